### hdl/adsrle_pkg.sv
// shared types, codes and exponent tables for the log-domain adsr envelope
package adsrle_pkg;

    localparam int unsigned LEVEL_W = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned EXP_TBL_DEPTH = 64;
    localparam int unsigned EXP_IDX_W = $clog2(EXP_TBL_DEPTH);

    typedef logic [LEVEL_W-1:0] t_level;

    typedef enum logic [2:0] {
        PH_OFF     = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_HOLD    = 3'd2,
        PH_DECAY   = 3'd3,
        PH_SUSTAIN = 3'd4,
        PH_RELEASE = 3'd5
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK_RATE   = 2'd0,
        CFG_DECAY_RATE    = 2'd1,
        CFG_SUSTAIN_LEVEL = 2'd2,
        CFG_RELEASE_RATE  = 2'd3
    } t_cfg_idx;

    localparam t_level LEVEL_MAX      = 16'hffff;
    localparam t_level HOLD_EXIT_LVL  = 16'hfff1;
    localparam t_level ATTACK_RST     = 16'd255;
    localparam t_level DECAY_RST      = 16'd15;
    localparam t_level SUSTAIN_RST    = 16'd57344;
    localparam t_level RELEASE_RST    = 16'd15;
    localparam logic [4:0] SHIFT_BASE = 5'd31;

    localparam logic [15:0] COARSE_EXP [EXP_TBL_DEPTH] = '{
        16'd32768, 16'd33125, 16'd33486, 16'd33850, 16'd34219, 16'd34591, 16'd34968, 16'd35349,
        16'd35734, 16'd36123, 16'd36516, 16'd36914, 16'd37316, 16'd37722, 16'd38133, 16'd38548,
        16'd38968, 16'd39392, 16'd39821, 16'd40255, 16'd40693, 16'd41136, 16'd41584, 16'd42037,
        16'd42495, 16'd42958, 16'd43425, 16'd43898, 16'd44376, 16'd44859, 16'd45348, 16'd45842,
        16'd46341, 16'd46846, 16'd47356, 16'd47871, 16'd48393, 16'd48920, 16'd49452, 16'd49991,
        16'd50535, 16'd51085, 16'd51642, 16'd52204, 16'd52773, 16'd53347, 16'd53928, 16'd54515,
        16'd55109, 16'd55709, 16'd56316, 16'd56929, 16'd57549, 16'd58176, 16'd58809, 16'd59449,
        16'd60097, 16'd60751, 16'd61413, 16'd62081, 16'd62757, 16'd63441, 16'd64132, 16'd64830
    };

    localparam logic [15:0] FINE_EXP [EXP_TBL_DEPTH] = '{
        16'd32768, 16'd32774, 16'd32779, 16'd32785, 16'd32790, 16'd32796, 16'd32801, 16'd32807,
        16'd32812, 16'd32818, 16'd32823, 16'd32829, 16'd32835, 16'd32840, 16'd32846, 16'd32851,
        16'd32857, 16'd32862, 16'd32868, 16'd32874, 16'd32879, 16'd32885, 16'd32890, 16'd32896,
        16'd32901, 16'd32907, 16'd32912, 16'd32918, 16'd32924, 16'd32929, 16'd32935, 16'd32940,
        16'd32946, 16'd32952, 16'd32957, 16'd32963, 16'd32968, 16'd32974, 16'd32979, 16'd32985,
        16'd32991, 16'd32996, 16'd33002, 16'd33007, 16'd33013, 16'd33018, 16'd33024, 16'd33030,
        16'd33035, 16'd33041, 16'd33046, 16'd33052, 16'd33058, 16'd33063, 16'd33069, 16'd33074,
        16'd33080, 16'd33086, 16'd33091, 16'd33097, 16'd33102, 16'd33108, 16'd33114, 16'd33119
    };

endpackage

### hdl/adsrle_if.sv
// channel interfaces: tick input, level output and register write
interface adsrle_tick_if;
    logic valid;
    logic ready;
    logic trigger;
    logic gate;

    modport source (output valid, output trigger, output gate, input ready);
    modport sink (input valid, input trigger, input gate, output ready);
endinterface

interface adsrle_level_if;
    import adsrle_pkg::*;
    logic   valid;
    logic   ready;
    t_level linear_level;
    t_level log_level;
    t_phase phase;
    logic   active;

    modport source (output valid, output linear_level, output log_level, output phase,
                    output active, input ready);
    modport sink (input valid, input linear_level, input log_level, input phase,
                  input active, output ready);
endinterface

interface adsrle_cfg_if;
    import adsrle_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_level               data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/adsrle_lin_conv.sv
// log level to linear level: coarse times fine exponent entry, shifted by octave
module adsrle_lin_conv (
    input  adsrle_pkg::t_level i_log_level,
    output adsrle_pkg::t_level o_linear_level
);
    import adsrle_pkg::*;

    logic [EXP_IDX_W-1:0] coarse_idx;
    logic [EXP_IDX_W-1:0] fine_idx;
    logic [3:0]           octave;
    logic [31:0]          prod;
    logic [4:0]           shamt;
    logic [31:0]          shifted;

    assign coarse_idx = i_log_level[11:6];
    assign fine_idx   = i_log_level[5:0];
    assign octave     = i_log_level[15:12];
    assign prod       = COARSE_EXP[coarse_idx] * FINE_EXP[fine_idx];
    assign shamt      = SHIFT_BASE - {1'b0, octave};
    assign shifted    = prod >> shamt;

    // a zero log level means silence, not the table floor
    assign o_linear_level = (i_log_level == '0) ? '0 : shifted[15:0];

endmodule

### hdl/adsr_log_envelope_generator.sv
// Log-domain ADSR envelope generator, one control-rate tick per input transaction.
//
// i_tick carries trigger and gate for one tick; o_level returns one transaction per
// tick with the linear level, the log level (4Q12), the phase and an active flag.
// i_cfg writes attack rate, decay rate, sustain level and release rate by index;
// it is always ready and should be used only while no tick is in flight.
//
// Pipeline: input register, envelope update (phase/level state), linear conversion
// into the output register. One tick per cycle is sustained while o_level.ready
// stays high; the state update of one tick completes in the same cycle as the next
// one reaches it, so ticks may arrive back to back.
//
// When o_level.ready is low the output register holds and the stages behind it
// fill up; i_tick.ready drops once the input register is occupied and blocked.
// Synchronous reset clears the pipeline, sets the phase to off with level zero and
// loads the default register values (attack 255, decay 15, sustain 57344, release 15).
module adsr_log_envelope_generator (
    input logic          i_clk,
    input logic          i_rst_n,
    adsrle_tick_if.sink  i_tick,
    adsrle_level_if.source o_level,
    adsrle_cfg_if.sink   i_cfg
);
    import adsrle_pkg::*;

    // configuration
    t_level r_attack_rate;
    t_level r_decay_rate;
    t_level r_sustain_level;
    t_level r_release_rate;

    // input stage
    logic r_in_valid;
    logic r_in_trigger;
    logic r_in_gate;

    // envelope state
    t_phase r_env_phase;
    t_level r_env_level;
    t_phase n_env_phase;
    t_level n_env_level;

    // update stage
    logic   r_st_valid;
    t_level r_st_level;
    t_phase r_st_phase;

    // output stage
    logic   r_out_valid;
    t_level r_out_linear;
    t_level r_out_log;
    t_phase r_out_phase;

    logic   out_adv;
    logic   st_adv;
    logic   in_adv;
    logic   step;
    t_level conv_linear;

    t_phase      phase_trig;
    logic [16:0] sum_attack;
    logic [16:0] diff_decay;
    logic [16:0] diff_release;

    assign out_adv = !r_out_valid || o_level.ready;
    assign st_adv  = !r_st_valid || out_adv;
    assign in_adv  = !r_in_valid || st_adv;
    assign step    = r_in_valid && st_adv;

    assign i_tick.ready = in_adv;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_rate   <= ATTACK_RST;
            r_decay_rate    <= DECAY_RST;
            r_sustain_level <= SUSTAIN_RST;
            r_release_rate  <= RELEASE_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_ATTACK_RATE:   r_attack_rate   <= i_cfg.data;
                CFG_DECAY_RATE:    r_decay_rate    <= i_cfg.data;
                CFG_SUSTAIN_LEVEL: r_sustain_level <= i_cfg.data;
                CFG_RELEASE_RATE:  r_release_rate  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_adv) begin
            r_in_valid <= i_tick.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_tick.valid) begin
            r_in_trigger <= i_tick.trigger;
            r_in_gate    <= i_tick.gate;
        end
    end

    assign sum_attack   = {1'b0, r_env_level} + {1'b0, r_attack_rate};
    assign diff_decay   = {1'b0, r_env_level} - {1'b0, r_decay_rate};
    assign diff_release = {1'b0, r_env_level} - {1'b0, r_release_rate};
    assign phase_trig   = r_in_trigger ? PH_ATTACK : r_env_phase;

    always_comb begin
        n_env_level = r_env_level;
        n_env_phase = phase_trig;
        if (phase_trig == PH_OFF) begin
            n_env_level = '0;
        end else begin
            if (!r_in_gate) begin
                n_env_phase = PH_RELEASE;
            end
            case (n_env_phase)
                PH_ATTACK: begin
                    if (sum_attack[16]) begin
                        n_env_level = LEVEL_MAX;
                        n_env_phase = PH_HOLD;
                    end else begin
                        n_env_level = sum_attack[15:0];
                    end
                end
                PH_HOLD: begin
                    // wraps to all ones from zero, which also ends the hold
                    n_env_level = r_env_level - 16'd1;
                    if (r_env_level <= HOLD_EXIT_LVL) begin
                        n_env_phase = PH_DECAY;
                    end
                end
                PH_DECAY: begin
                    if (diff_decay[16] || (diff_decay[15:0] < r_sustain_level)) begin
                        n_env_level = r_sustain_level;
                        n_env_phase = PH_SUSTAIN;
                    end else begin
                        n_env_level = diff_decay[15:0];
                    end
                end
                PH_RELEASE: begin
                    if (diff_release[16]) begin
                        n_env_level = '0;
                        n_env_phase = PH_OFF;
                    end else begin
                        n_env_level = diff_release[15:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env_phase <= PH_OFF;
            r_env_level <= '0;
            r_st_valid  <= 1'b0;
        end else begin
            if (step) begin
                r_env_phase <= n_env_phase;
                r_env_level <= n_env_level;
            end
            if (st_adv) begin
                r_st_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_st_level <= n_env_level;
            r_st_phase <= n_env_phase;
        end
    end

    adsrle_lin_conv u_lin_conv (
        .i_log_level    (r_st_level),
        .o_linear_level (conv_linear)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_st_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_st_valid) begin
            r_out_linear <= conv_linear;
            r_out_log    <= r_st_level;
            r_out_phase  <= r_st_phase;
        end
    end

    assign o_level.valid        = r_out_valid;
    assign o_level.linear_level = r_out_linear;
    assign o_level.log_level    = r_out_log;
    assign o_level.phase        = r_out_phase;
    assign o_level.active       = (r_out_phase != PH_OFF);

endmodule

### hdl/adsrle_checker.sv
// port-level checks for the envelope generator, bound to the top level
module adsrle_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input adsrle_pkg::t_level i_linear_level,
    input adsrle_pkg::t_level i_log_level,
    input adsrle_pkg::t_phase i_phase,
    input logic               i_active
);
    import adsrle_pkg::*;

    // active flag tracks the phase
    a_active_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_active == (i_phase != PH_OFF)))
        else $error("active flag disagrees with phase");

    // an idle envelope is silent in both domains
    a_off_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_phase == PH_OFF) |-> (i_log_level == '0 && i_linear_level == '0))
        else $error("off phase with nonzero level");

    // hold only ever sits just below full scale
    a_hold_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_phase == PH_HOLD) |-> (i_log_level > 16'hfff0))
        else $error("hold phase below its exit level");

    // a stalled transaction stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_log_level) && $stable(i_linear_level)
             && $stable(i_phase)))
        else $error("output changed while stalled");

endmodule

bind adsr_log_envelope_generator adsrle_checker u_adsrle_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_level.valid),
    .i_out_ready    (o_level.ready),
    .i_linear_level (o_level.linear_level),
    .i_log_level    (o_level.log_level),
    .i_phase        (o_level.phase),
    .i_active       (o_level.active)
);

### test/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the log-domain adsr envelope generator
module tb_top;
    import adsrle_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned TAIL_CYCLES = 8;
    localparam int unsigned PHASE_TICKS = 100;
    localparam int unsigned NUM_PHASES = 12;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        t_level linear_level;
        t_level log_level;
        t_phase phase;
        logic   active;
    } t_level_sample;

    logic i_clk = 1'b0;
    logic i_rst_n;

    adsrle_tick_if  tick_if ();
    adsrle_level_if level_if ();
    adsrle_cfg_if   cfg_if ();

    adsr_log_envelope_generator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_if),
        .o_level (level_if),
        .i_cfg   (cfg_if)
    );

    // envelope state and register shadow
    t_phase env_ph;
    t_level env_lvl;
    int     atk_rate;
    int     dcy_rate;
    int     sus_level;
    int     rel_rate;

    t_level_sample expected_levels[$];
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count = 0;
    int unsigned   src_idle_pct = 0;
    int unsigned   snk_idle_pct = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_level log_to_linear(input t_level lvl);
        logic [31:0] prod;
        logic [4:0]  shift;
        if (lvl == '0) begin
            return '0;
        end
        prod = COARSE_EXP[lvl[11:6]] * FINE_EXP[lvl[5:0]];
        shift = SHIFT_BASE - {1'b0, lvl[15:12]};
        return t_level'(prod >> shift);
    endfunction

    function automatic t_level_sample advance_envelope(input logic trig, input logic gate);
        int            lv;
        t_level_sample res;
        lv = env_lvl;
        if (trig) begin
            env_ph = PH_ATTACK;
        end
        if (env_ph == PH_OFF) begin
            lv = 0;
        end else begin
            if (!gate) begin
                env_ph = PH_RELEASE;
            end
            case (env_ph)
                PH_ATTACK: begin
                    lv = lv + atk_rate;
                    if (lv >= 65536) begin
                        lv = 65535;
                        env_ph = PH_HOLD;
                    end
                end
                PH_HOLD: begin
                    lv = lv - 1;
                    if (lv <= 65520) begin
                        env_ph = PH_DECAY;
                    end
                end
                PH_DECAY: begin
                    lv = lv - dcy_rate;
                    if (lv < sus_level) begin
                        lv = sus_level;
                        env_ph = PH_SUSTAIN;
                    end
                end
                PH_RELEASE: begin
                    lv = lv - rel_rate;
                    if (lv < 0) begin
                        lv = 0;
                        env_ph = PH_OFF;
                    end
                end
                default: ;
            endcase
        end
        env_lvl = lv[15:0];
        res.linear_level = log_to_linear(env_lvl);
        res.log_level = env_lvl;
        res.phase = env_ph;
        res.active = (env_ph != PH_OFF);
        return res;
    endfunction

    // one tick transaction, with an optional random gap in front
    task automatic send_tick(input logic trig, input logic gate);
        if ($urandom_range(99) < src_idle_pct) begin
            tick_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        tick_if.valid <= 1'b1;
        tick_if.trigger <= trig;
        tick_if.gate <= gate;
        do @(posedge i_clk); while (!tick_if.ready);
        expected_levels.push_back(advance_envelope(trig, gate));
    endtask

    task automatic drain_results();
        tick_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_levels.size() != 0);
    endtask

    // writes all four registers back to back once the pipeline is empty
    task automatic set_config(input t_level atk, input t_level dcy, input t_level sus,
                              input t_level rel);
        t_cfg_idx order [4];
        t_level   vals [4];
        int       i;
        order = '{CFG_ATTACK_RATE, CFG_DECAY_RATE, CFG_SUSTAIN_LEVEL, CFG_RELEASE_RATE};
        vals = '{atk, dcy, sus, rel};
        drain_results();
        for (i = 0; i < 4; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= order[i];
            cfg_if.data <= vals[i];
            do @(posedge i_clk); while (!cfg_if.ready);
            case (order[i])
                CFG_ATTACK_RATE:   atk_rate = vals[i];
                CFG_DECAY_RATE:    dcy_rate = vals[i];
                CFG_SUSTAIN_LEVEL: sus_level = vals[i];
                CFG_RELEASE_RATE:  rel_rate = vals[i];
                default: ;
            endcase
        end
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_idling(input int unsigned src, input int unsigned snk);
        src_idle_pct = src;
        snk_idle_pct = snk;
    endtask

    // default registers: off phase, trigger with gate low, retrigger, release
    task automatic test_power_up();
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        drain_results();
    endtask

    // attack and release rates of zero hold their level
    task automatic test_zero_rates();
        set_config('0, DECAY_RST, SUSTAIN_RST, '0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        drain_results();
    endtask

    // full attack, hold countdown, decay rising to a sustain level above it
    task automatic test_sustain_above_decay();
        set_config(LEVEL_MAX, 16'd1, LEVEL_MAX, LEVEL_MAX);
        send_tick(1'b1, 1'b1);
        repeat (17) send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        drain_results();
    endtask

    // mostly note on / hold / note off sequences, some random ticks
    task automatic play_notes(input int unsigned count);
        int unsigned sent;
        int unsigned held;
        int unsigned released;
        int unsigned noise;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 80) begin
                held = ($urandom_range(9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 50);
                released = $urandom_range(1, 40);
                send_tick(1'b1, 1'b1);
                repeat (held) send_tick(($urandom_range(99) < 3), 1'b1);
                repeat (released) send_tick(1'b0, 1'b0);
                sent += 1 + held + released;
            end else begin
                noise = $urandom_range(1, 8);
                repeat (noise) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
                sent += noise;
            end
            // let the pipeline run dry now and then
            if ($urandom_range(99) < 5) begin
                drain_results();
            end
        end
    endtask

    task automatic test_random_notes();
        int unsigned k;
        t_level      atk;
        t_level      dcy;
        t_level      sus;
        t_level      rel;
        for (k = 0; k < NUM_PHASES; k++) begin
            atk = ($urandom_range(3) == 0) ? t_level'($urandom_range(0, 255))
                                           : t_level'($urandom_range(2048, 65535));
            dcy = t_level'($urandom_range(0, 65535) >> $urandom_range(0, 12));
            sus = t_level'($urandom_range(0, 65535));
            rel = t_level'($urandom_range(0, 65535) >> $urandom_range(0, 8));
            case (k)
                0: set_config('0, '0, '0, '0);
                1: set_config(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
                2: set_config(ATTACK_RST, DECAY_RST, SUSTAIN_RST, RELEASE_RST);
                3: set_config(atk, dcy, LEVEL_MAX, rel);
                4: set_config(atk, dcy, '0, rel);
                default: set_config(atk, dcy, sus, rel);
            endcase
            case (k % 4)
                0: set_idling(0, 0);
                1: set_idling(47, 0);
                2: set_idling(0, 47);
                default: set_idling(30, 30);
            endcase
            play_notes(PHASE_TICKS);
        end
        set_idling(0, 0);
        drain_results();
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        level_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_level_sample exp_lvl;
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else if (i_rst_n && level_if.valid && level_if.ready) begin
            if (expected_levels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected level transaction: lin=%h log=%h phase=%0d active=%b",
                             level_if.linear_level, level_if.log_level, level_if.phase,
                             level_if.active);
                end
            end else begin
                exp_lvl = expected_levels.pop_front();
                if (level_if.linear_level !== exp_lvl.linear_level ||
                    level_if.log_level !== exp_lvl.log_level ||
                    level_if.phase !== exp_lvl.phase ||
                    level_if.active !== exp_lvl.active) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("level mismatch: exp lin=%h log=%h phase=%0d active=%b",
                                 exp_lvl.linear_level, exp_lvl.log_level, exp_lvl.phase,
                                 exp_lvl.active);
                        $display("                got lin=%h log=%h phase=%0d active=%b",
                                 level_if.linear_level, level_if.log_level, level_if.phase,
                                 level_if.active);
                    end
                end
            end
        end
    end

    initial begin
        env_ph = PH_OFF;
        env_lvl = '0;
        atk_rate = ATTACK_RST;
        dcy_rate = DECAY_RST;
        sus_level = SUSTAIN_RST;
        rel_rate = RELEASE_RST;
        i_rst_n = 1'b0;
        tick_if.valid = 1'b0;
        tick_if.trigger = 1'b0;
        tick_if.gate = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_ATTACK_RATE;
        cfg_if.data = '0;
        level_if.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_power_up();
        test_zero_rates();
        test_sustain_above_decay();
        test_random_notes();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_levels.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
